FILE: src/sse_data_line_parser_macros.svh
// Assertion macros for the event-stream data line parser.
// Included by sse_data_line_parser, the only RTL file that carries concurrent assertions; no other dependencies.
`ifndef SSE_DATA_LINE_PARSER_MACROS_SVH
`define SSE_DATA_LINE_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define SDLP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define SDLP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/sdlp_pkg.sv
// Types, byte codes and the per-byte line step function of the event-stream data line parser.
// Used by sse_data_line_parser, its checker and its testbench; depends on nothing else.
package sdlp_pkg;

	localparam logic [7:0] BYTE_LF    = 8'h0A;
	localparam logic [7:0] BYTE_CR    = 8'h0D;
	localparam logic [7:0] BYTE_SPACE = 8'h20;
	localparam logic [7:0] BYTE_COLON = 8'h3A;

	localparam logic [2:0] KEY_LEN = 3'd5;

	localparam logic [2:0] PH_START   = 3'd0;
	localparam logic [2:0] PH_PREFIX  = 3'd1;
	localparam logic [2:0] PH_SPACE   = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_SKIP    = 3'd4;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = FIFO_AW + 1;

	typedef struct packed {
		logic [2:0] phase;
		logic [2:0] pos;
		logic       data_seen;
	} lstate_t;

	typedef struct packed {
		logic       event_end;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		lstate_t    st;
		logic       emit;
		logic [7:0] data;
	} step_t;

	// Characters of the "data:" field name, by position.
	function automatic logic [7:0] key_char(input logic [2:0] pos);
		logic [7:0] k;
		unique case (pos)
			3'd0: k = 8'h64;
			3'd1: k = 8'h61;
			3'd2: k = 8'h74;
			3'd3: k = 8'h61;
			3'd4: k = BYTE_COLON;
			default: k = 8'h00;
		endcase
		return k;
	endfunction

	// Advances the line state by one byte that belongs to the line (never LF).
	function automatic step_t line_byte(input lstate_t st, input logic [7:0] c);
		step_t r;
		r.st   = st;
		r.emit = 1'b0;
		r.data = c;
		unique case (st.phase)
			PH_START: begin
				if (c == key_char(3'd0)) begin
					r.st.phase = PH_PREFIX;
					r.st.pos   = 3'd1;
				end else begin
					r.st.phase = PH_SKIP;
				end
			end
			PH_PREFIX: begin
				if (st.pos < KEY_LEN && c == key_char(st.pos)) begin
					r.st.pos = st.pos + 3'd1;
					if (st.pos + 3'd1 == KEY_LEN) begin
						if (st.data_seen) begin
							r.emit = 1'b1;
							r.data = BYTE_LF;
						end
						r.st.data_seen = 1'b1;
						r.st.phase     = PH_SPACE;
					end
				end else begin
					r.st.phase = PH_SKIP;
				end
			end
			PH_SPACE: begin
				r.emit     = (c != BYTE_SPACE);
				r.st.phase = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				r.emit = 1'b1;
			end
			default: begin
				r.st.phase = PH_SKIP;
			end
		endcase
		return r;
	endfunction

endpackage

FILE: src/sse_data_line_parser.sv
// Top level of the event-stream data line parser: input register, line state and output queue.
// Depends on sdlp_pkg and sse_data_line_parser_macros.svh.

// The parser takes one raw event-stream byte per cycle and streams out the payload bytes of
// the "data:" lines of each event, an LF item between data lines of one event, and an end
// marker (event_end high, out_byte zero) at the blank line that closes an event with data.
// A byte is registered on acceptance and evaluated from that register, where it waits
// while the queue lacks room. The results go into a four-entry queue whose head drives the
// output and that the output side drains at one result per cycle while out_ready is high;
// a byte is evaluated only while the queue has room for two results. Bytes that give at
// most one result are therefore taken at one per cycle, while a byte that gives two results
// (a held CR that turns out to be line content, followed by a payload byte) puts one extra
// result into the queue, which the queue absorbs or passes back as backpressure on in_ready.
module sse_data_line_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       in_valid,
	output logic       in_ready,
	output logic [7:0] out_byte,
	output logic       event_end,
	output logic       out_valid,
	input  logic       out_ready
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	logic [2:0] phase_q;
	logic [2:0] pos_q;
	logic       cr_held_q;
	logic       data_seen_q;

	sdlp_pkg::item_t                       mem_q [sdlp_pkg::FIFO_DEPTH];
	logic [sdlp_pkg::FIFO_AW-1:0]          wr_ptr_q;
	logic [sdlp_pkg::FIFO_AW-1:0]          rd_ptr_q;
	logic [sdlp_pkg::CNT_W-1:0]            cnt_q;

	logic                                  room;
	logic                                  fire_s1;
	logic                                  pop;
	logic                                  is_lf;
	logic                                  is_cr;
	logic                                  end_push;
	sdlp_pkg::lstate_t                     st_cur;
	sdlp_pkg::step_t                       step_a;
	sdlp_pkg::step_t                       step_b;
	sdlp_pkg::lstate_t                     st_next;
	logic                                  cr_next;
	logic                                  push_a;
	logic                                  push_b;
	sdlp_pkg::item_t                       item0;
	sdlp_pkg::item_t                       item1;
	logic [1:0]                            npush;
	sdlp_pkg::item_t                       head;
	logic                                  line_idle;

	assign room     = cnt_q <= sdlp_pkg::CNT_W'(sdlp_pkg::FIFO_DEPTH - 2);
	assign fire_s1  = valid_s1 && room;
	assign in_ready = !valid_s1 || fire_s1;
	assign pop      = out_valid && out_ready;

	assign is_lf  = byte_s1 == sdlp_pkg::BYTE_LF;
	assign is_cr  = byte_s1 == sdlp_pkg::BYTE_CR;
	assign st_cur = '{phase: phase_q, pos: pos_q, data_seen: data_seen_q};

	always_comb begin
		step_a   = '{st: st_cur, emit: 1'b0, data: sdlp_pkg::BYTE_CR};
		step_b   = '{st: st_cur, emit: 1'b0, data: byte_s1};
		end_push = 1'b0;
		st_next  = st_cur;
		cr_next  = cr_held_q;
		if (is_lf) begin
			end_push          = (phase_q == sdlp_pkg::PH_START) && data_seen_q;
			st_next.phase     = sdlp_pkg::PH_START;
			st_next.pos       = 3'd0;
			st_next.data_seen = data_seen_q && !end_push;
			cr_next           = 1'b0;
		end else begin
			if (cr_held_q) begin
				step_a = sdlp_pkg::line_byte(st_cur, sdlp_pkg::BYTE_CR);
			end
			if (is_cr) begin
				step_b = '{st: step_a.st, emit: 1'b0, data: byte_s1};
			end else begin
				step_b = sdlp_pkg::line_byte(step_a.st, byte_s1);
			end
			st_next = step_b.st;
			cr_next = is_cr;
		end
	end

	always_comb begin
		push_a = !is_lf && step_a.emit;
		push_b = !is_lf && step_b.emit;
		if (is_lf) begin
			item0 = '{event_end: 1'b1, data: 8'h00};
			npush = {1'b0, end_push};
		end else begin
			item0 = push_a ? '{event_end: 1'b0, data: step_a.data}
				: '{event_end: 1'b0, data: step_b.data};
			npush = {1'b0, push_a} + {1'b0, push_b};
		end
		item1 = '{event_end: 1'b0, data: step_b.data};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= sdlp_pkg::PH_START;
			pos_q       <= 3'd0;
			cr_held_q   <= 1'b0;
			data_seen_q <= 1'b0;
		end else if (fire_s1) begin
			phase_q     <= st_next.phase;
			pos_q       <= st_next.pos;
			cr_held_q   <= cr_next;
			data_seen_q <= st_next.data_seen;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && npush != 2'd0) begin
			mem_q[wr_ptr_q] <= item0;
		end
		if (fire_s1 && npush == 2'd2) begin
			mem_q[wr_ptr_q + sdlp_pkg::FIFO_AW'(1)] <= item1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (fire_s1) begin
				wr_ptr_q <= wr_ptr_q + sdlp_pkg::FIFO_AW'(npush);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + sdlp_pkg::FIFO_AW'(1);
			end
			cnt_q <= cnt_q + (fire_s1 ? sdlp_pkg::CNT_W'(npush) : '0)
				- sdlp_pkg::CNT_W'(pop);
		end
	end

	assign head      = mem_q[rd_ptr_q];
	assign out_valid = cnt_q != '0;
	assign out_byte  = head.data;
	assign event_end = head.event_end;

	assign line_idle = phase_q == sdlp_pkg::PH_START && !cr_held_q && pos_q == 3'd0;

`include "sse_data_line_parser_macros.svh"

	`SDLP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= sdlp_pkg::CNT_W'(sdlp_pkg::FIFO_DEPTH), "queue overflow")
	`SDLP_ASSERT_NOW(a_end_zero, out_valid && event_end, out_byte == 8'h00, "non-zero end marker")
	`SDLP_ASSERT_NEXT(a_lf_restart, fire_s1 && is_lf, line_idle, "LF did not restart the line")
	`SDLP_ASSERT_NEXT(a_end_clears, fire_s1 && end_push, !data_seen_q, "data flag survived an end marker")

endmodule

FILE: tb/sv/sse_data_line_parser_checker.sv
// Result checker for the event-stream data line parser: watches both channels,
// predicts the result items of every accepted byte and compares them in order.
// Depends on sdlp_pkg for the byte codes, line phases and the result item type.
module sse_data_line_parser_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] out_byte,
	input  logic       event_end,
	input  logic       out_valid,
	input  logic       out_ready,
	output int         fail_count,
	output int         pending_cnt
);
	import sdlp_pkg::*;

	localparam logic [39:0] DATA_KEY = "data:";

	item_t      expected_items[$];
	logic [2:0] ln_phase     = PH_START;
	logic [2:0] key_pos      = 3'd0;
	logic       cr_waiting   = 1'b0;
	logic       evt_has_data = 1'b0;

	initial begin
		fail_count  = 0;
		pending_cnt = 0;
	end

	function automatic logic [7:0] key_at(input logic [2:0] p);
		return DATA_KEY[39 - 8 * p -: 8];
	endfunction

	task automatic push_item(input logic [7:0] b, input logic e);
		item_t it;
		it.data      = b;
		it.event_end = e;
		expected_items.push_back(it);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic feed_line_char(input logic [7:0] c);
		case (ln_phase)
			PH_START: begin
				if (c == key_at(3'd0)) begin
					ln_phase = PH_PREFIX;
					key_pos  = 3'd1;
				end else begin
					ln_phase = PH_SKIP;
				end
			end
			PH_PREFIX: begin
				if (key_pos < KEY_LEN && c == key_at(key_pos)) begin
					key_pos = key_pos + 3'd1;
					if (key_pos == KEY_LEN) begin
						if (evt_has_data)
							push_item(BYTE_LF, 1'b0);
						evt_has_data = 1'b1;
						ln_phase     = PH_SPACE;
					end
				end else begin
					ln_phase = PH_SKIP;
				end
			end
			PH_SPACE: begin
				if (c != BYTE_SPACE)
					push_item(c, 1'b0);
				ln_phase = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				push_item(c, 1'b0);
			end
			default: begin
				ln_phase = PH_SKIP;
			end
		endcase
	endtask

	task automatic parse_stream_byte(input logic [7:0] c);
		if (c == BYTE_LF) begin
			cr_waiting = 1'b0;
			if (ln_phase == PH_START && evt_has_data) begin
				push_item(8'h00, 1'b1);
				evt_has_data = 1'b0;
			end
			ln_phase = PH_START;
			key_pos  = 3'd0;
		end else begin
			if (cr_waiting) begin
				feed_line_char(BYTE_CR);
				cr_waiting = 1'b0;
			end
			if (c == BYTE_CR)
				cr_waiting = 1'b1;
			else
				feed_line_char(c);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t want;
		if (!arst_n) begin
			ln_phase     = PH_START;
			key_pos      = 3'd0;
			cr_waiting   = 1'b0;
			evt_has_data = 1'b0;
			expected_items.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_items.size() == 0) begin
					report_mismatch("result with nothing expected",
						int'({event_end, out_byte}), 0);
				end else begin
					want = expected_items.pop_front();
					if (event_end !== want.event_end)
						report_mismatch("event_end", int'(event_end),
							int'(want.event_end));
					if (out_byte !== want.data)
						report_mismatch("out_byte", int'(out_byte), int'(want.data));
				end
			end
			if (in_valid && in_ready)
				parse_stream_byte(in_byte);
		end
		pending_cnt = expected_items.size();
	end

endmodule

FILE: tb/sv/tb_sse_data_line_parser.sv
// Testbench top for the event-stream data line parser: clock, reset, byte stimulus,
// output back-pressure and the verdict.
// Depends on sdlp_pkg, sse_data_line_parser and sse_data_line_parser_checker.
module tb_sse_data_line_parser;
	import sdlp_pkg::*;

	localparam int    CYCLE_LIMIT  = 200000;
	localparam int    RANDOM_BYTES = 600;
	localparam int    HOLD_CYCLES  = 200;
	localparam int    DRAIN_CYCLES = 16;
	localparam string DATA_TEXT    = "data:";

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic [7:0] in_byte   = 8'h00;
	logic       in_valid  = 1'b0;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic [7:0] out_byte;
	logic       event_end;
	logic       out_valid;

	int fail_count;
	int pending_cnt;
	int cycles     = 0;
	int sent       = 0;
	int taken      = 0;
	bit hold_req   = 1'b0;
	bit snd_steady = 1'b0;
	bit rcv_steady = 1'b0;

	always #1 clk = ~clk;

	sse_data_line_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (in_byte),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_byte  (out_byte),
		.event_end (event_end),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

	sse_data_line_parser_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_byte     (in_byte),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.out_byte    (out_byte),
		.event_end   (event_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.fail_count  (fail_count),
		.pending_cnt (pending_cnt)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Each request is held with its byte unchanged until the parser accepts it.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = snd_steady ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_byte  = b;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		sent++;
		if (sent % 40 == 0)
			snd_steady = ($urandom_range(0, 3) == 0);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_random_line();
		int         kind;
		int         len;
		logic [7:0] b;
		kind = $urandom_range(0, 15);
		if (kind <= 6) begin
			send_text(DATA_TEXT);
			if ($urandom_range(0, 1))
				send_byte(BYTE_SPACE);
			len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
			repeat (len) begin
				b = 8'($urandom_range(0, 255));
				if (b == BYTE_LF)
					b = BYTE_CR;
				send_byte(b);
			end
		end else if (kind == 7) begin
			send_byte(BYTE_COLON);
			send_text(" keep-alive");
		end else if (kind == 8) begin
			send_text(($urandom_range(0, 1)) ? "event: update" : "id:7");
		end else if (kind == 9) begin
			len = $urandom_range(1, 4);
			send_text(DATA_TEXT.substr(0, len - 1));
			if ($urandom_range(0, 1)) begin
				b = 8'($urandom_range(0, 255));
				if (b == BYTE_LF)
					b = BYTE_SPACE;
				send_byte(b);
			end
		end else if (kind == 10) begin
			send_text(($urandom_range(0, 1)) ? "DATA: up" : "Data:x");
		end else if (kind == 14) begin
			repeat ($urandom_range(1, 6))
				send_byte(8'($urandom_range(0, 255)));
		end else if (kind == 15) begin
			send_byte(BYTE_CR);
		end
		if ($urandom_range(0, 1))
			send_byte(BYTE_CR);
		send_byte(BYTE_LF);
	endtask

	initial begin
		int         w;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req  = 1'b0;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				w = rcv_steady ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0);
				if (w > 0) begin
					out_ready = 1'b0;
					repeat (w) @(negedge clk);
				end
			end
			out_ready = 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
			taken++;
			if (taken % 30 == 0)
				rcv_steady = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		int         goal;
		bit         burst_done;
		bit         pause_done;
		logic [7:0] b;
		burst_done = 1'b0;
		pause_done = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_text("data: ");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(BYTE_CR);
		send_byte(BYTE_CR);
		send_text("A");
		send_byte(BYTE_LF);
		send_text("data:");
		send_byte(BYTE_LF);
		send_byte(BYTE_CR);
		send_byte(BYTE_LF);
		send_byte(BYTE_COLON);
		send_byte(BYTE_LF);
		send_text("dat");
		send_byte(BYTE_LF);
		send_byte(BYTE_LF);
		send_text("DATA:");
		send_byte(BYTE_LF);

		goal = sent + RANDOM_BYTES;
		while (sent < goal) begin
			if (!burst_done && sent >= goal - (2 * RANDOM_BYTES) / 3) begin
				burst_done = 1'b1;
				hold_req   = 1'b1;
				snd_steady = 1'b1;
				send_text("data: ");
				repeat (40) begin
					b = 8'($urandom_range(0, 255));
					if (b == BYTE_LF)
						b = 8'h41;
					send_byte(b);
				end
				send_byte(BYTE_LF);
				snd_steady = 1'b0;
			end else if (!pause_done && sent >= goal - RANDOM_BYTES / 3) begin
				pause_done = 1'b1;
				in_valid   = 1'b0;
				while (pending_cnt != 0) @(negedge clk);
			end else begin
				send_random_line();
			end
		end
		in_valid = 1'b0;

		while (pending_cnt != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+src
src/sdlp_pkg.sv
src/sse_data_line_parser.sv
tb/sv/sse_data_line_parser_checker.sv
tb/sv/tb_sse_data_line_parser.sv
